// ===== rtl/sgi_pkg.sv =====
// Shared types and constants for the scan gap interpolation block.
package sgi_pkg;

    // Field widths.
    localparam int RANGE_W = 16;
    localparam int COUNT_W = 13;
    localparam int CFG_W   = 16;

    // Longest gap run that is counted; longer runs saturate here.
    localparam int MAX_SCAN_POINTS = 4096;
    localparam int RUN_W = $clog2(MAX_SCAN_POINTS + 1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_VALID = 2'd0,
        CFG_MAX_VALID = 2'd1,
        CFG_FILL_DEF  = 2'd2
    } cfg_index_t;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] MIN_VALID_RST = 16'd500;
    localparam logic [CFG_W-1:0] MAX_VALID_RST = 16'd25000;
    localparam logic [CFG_W-1:0] FILL_DEF_RST  = 16'd10000;

    // Result queue sizing.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    // One result transaction.
    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic [COUNT_W-1:0] count;
        logic               filled;
        logic               last;
        logic               done;
    } result_t;

    // Truncated mean of two ranges through a 17-bit sum.
    function automatic logic [RANGE_W-1:0] mean_mm(input logic [RANGE_W-1:0] a,
                                                    input logic [RANGE_W-1:0] b);
        logic [RANGE_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[RANGE_W:1];
    endfunction

endpackage

// ===== rtl/scan_gap_interpolation.sv =====
// Top level of the scan gap interpolation block.
//
// Input channel: one lidar range sample per transaction (range_mm) with
// end_of_scan on the final point, accepted when in_valid is high and
// in_stall is low. Output channel: result transactions on out_valid and
// out_stall, each a range with a repeat count and flags.
// An input transaction yields zero, one or two results. All state updates
// happen in the cycle the sample is accepted and the results are written
// into a four-entry result queue and offered from its head in order. The
// block accepts one sample per cycle as long as the queue holds room for
// two results; the output side drains one result per cycle while out_stall
// is low, so samples that produce two results can fill the queue and raise
// in_stall until it drains. When the receiver stalls, the head result holds
// and the queue fills; in_stall rises once fewer than two slots are free.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the
// index past the last register is ignored. Reset clears the queue, loads
// the configuration defaults and sets both held ranges to the fill default.
module scan_gap_interpolation (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sgi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sgi_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [sgi_pkg::RANGE_W-1:0]         range_mm,
    input  logic                                end_of_scan,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [sgi_pkg::RANGE_W-1:0]         out_range_mm,
    output logic [sgi_pkg::COUNT_W-1:0]         repeat_count,
    output logic                                is_filled,
    output logic                                last_of_item,
    output logic                                scan_done
);

    logic [sgi_pkg::CFG_W-1:0]   min_valid_reg;
    logic [sgi_pkg::CFG_W-1:0]   max_valid_reg;
    logic [sgi_pkg::CFG_W-1:0]   fill_def_reg;

    logic [sgi_pkg::RANGE_W-1:0] prev_reg, prev_next;
    logic [sgi_pkg::RANGE_W-1:0] nextv_reg, nextv_next;
    logic [sgi_pkg::RUN_W-1:0]   run_reg, run_next;
    logic [sgi_pkg::RUN_W-1:0]   run_inc;

    logic                        accept;
    logic                        sample_ok;
    logic [1:0]                  wr_num;
    sgi_pkg::result_t            res0, res1, head;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_valid_reg <= sgi_pkg::MIN_VALID_RST;
            max_valid_reg <= sgi_pkg::MAX_VALID_RST;
            fill_def_reg  <= sgi_pkg::FILL_DEF_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sgi_pkg::CFG_MIN_VALID: min_valid_reg <= cfg_data;
                sgi_pkg::CFG_MAX_VALID: max_valid_reg <= cfg_data;
                sgi_pkg::CFG_FILL_DEF:  fill_def_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Classify the sample, build the results and the next held state.
    always_comb
    begin
        accept    = in_valid && !in_stall;
        sample_ok = (range_mm > min_valid_reg) && (range_mm < max_valid_reg);
        run_inc   = (run_reg < sgi_pkg::RUN_W'(sgi_pkg::MAX_SCAN_POINTS)) ?
                    run_reg + sgi_pkg::RUN_W'(1) : run_reg;

        prev_next  = prev_reg;
        nextv_next = nextv_reg;
        run_next   = run_reg;
        wr_num     = 2'd0;
        res0       = '0;
        res1       = '0;

        if (sample_ok)
        begin
            if (run_reg != '0)
            begin
                // Close the gap with a fill, then the sample itself.
                res0.range_mm = sgi_pkg::mean_mm(prev_reg, range_mm);
                res0.count    = sgi_pkg::COUNT_W'(run_reg);
                res0.filled   = 1'b1;
                res1.range_mm = range_mm;
                res1.count    = sgi_pkg::COUNT_W'(1);
                res1.last     = 1'b1;
                res1.done     = end_of_scan;
                nextv_next    = range_mm;
                wr_num        = 2'd2;
            end
            else
            begin
                res0.range_mm = range_mm;
                res0.count    = sgi_pkg::COUNT_W'(1);
                res0.last     = 1'b1;
                res0.done     = end_of_scan;
                wr_num        = 2'd1;
            end
            prev_next = range_mm;
            run_next  = '0;
        end
        else
        begin
            run_next = run_inc;
            if (end_of_scan)
            begin
                // Pending gap at end of scan uses the stale next value.
                res0.range_mm = sgi_pkg::mean_mm(prev_reg, nextv_reg);
                res0.count    = sgi_pkg::COUNT_W'(run_inc);
                res0.filled   = 1'b1;
                res0.last     = 1'b1;
                res0.done     = 1'b1;
                wr_num        = 2'd1;
            end
        end

        // End of scan returns the held values to the fill default.
        if (end_of_scan)
        begin
            prev_next  = fill_def_reg;
            nextv_next = fill_def_reg;
            run_next   = '0;
        end

        if (!accept)
        begin
            prev_next  = prev_reg;
            nextv_next = nextv_reg;
            run_next   = run_reg;
            wr_num     = 2'd0;
        end
    end

    // Held state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= sgi_pkg::FILL_DEF_RST;
            nextv_reg <= sgi_pkg::FILL_DEF_RST;
            run_reg   <= '0;
        end
        else
        begin
            prev_reg  <= prev_next;
            nextv_reg <= nextv_next;
            run_reg   <= run_next;
        end
    end

    // Result queue.
    sgi_res_fifo u_res_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_num   (wr_num),
        .wr_data0 (res0),
        .wr_data1 (res1),
        .no_room  (in_stall),
        .rd_valid (out_valid),
        .rd_stall (out_stall),
        .rd_data  (head)
    );

    assign out_range_mm = head.range_mm;
    assign repeat_count = head.count;
    assign is_filled    = head.filled;
    assign last_of_item = head.last;
    assign scan_done    = head.done;

    // The gap run never counts past its saturation point.
    assert property (@(posedge clk) disable iff (!rst_n)
        run_reg <= sgi_pkg::RUN_W'(sgi_pkg::MAX_SCAN_POINTS))
        else $error("gap run count exceeds its limit");

    // An accepted end of scan always leaves no pending gap.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_scan) |=> (run_reg == '0))
        else $error("gap run still pending after end of scan");

    // An accepted end of scan always produces at least one result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_scan) |=> out_valid)
        else $error("end of scan produced no result");

    // A scan-done result is always the last result of its transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && scan_done) |-> last_of_item)
        else $error("scan done flagged on a result that is not last");

endmodule

// ===== rtl/sgi_res_fifo.sv =====
// Result queue that takes up to two results per cycle and delivers one while rd_stall is low.
module sgi_res_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          wr_num,
    input  sgi_pkg::result_t    wr_data0,
    input  sgi_pkg::result_t    wr_data1,
    output logic                no_room,
    output logic                rd_valid,
    input  logic                rd_stall,
    output sgi_pkg::result_t    rd_data
);

    sgi_pkg::result_t                 mem [sgi_pkg::FIFO_DEPTH];
    logic [sgi_pkg::PTR_W-1:0]        wptr_reg, wptr_next;
    logic [sgi_pkg::PTR_W-1:0]        rptr_reg, rptr_next;
    logic [sgi_pkg::CNT_W-1:0]        count_reg, count_next;
    logic                             pop;
    logic [sgi_pkg::PTR_W-1:0]        wptr_plus1;

    // Pointer and fill count updates.
    always_comb
    begin
        pop        = rd_valid && !rd_stall;
        wptr_plus1 = wptr_reg + sgi_pkg::PTR_W'(1);
        wptr_next  = wptr_reg + sgi_pkg::PTR_W'(wr_num);
        rptr_next  = pop ? rptr_reg + sgi_pkg::PTR_W'(1) : rptr_reg;
        count_next = count_reg + sgi_pkg::CNT_W'(wr_num) - sgi_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage; the second write lands one slot after the first.
    always_ff @(posedge clk)
    begin
        if (wr_num != 2'd0)
        begin
            mem[wptr_reg] <= wr_data0;
        end
        if (wr_num == 2'd2)
        begin
            mem[wptr_plus1] <= wr_data1;
        end
    end

    // Read side and back-pressure: keep room for two results.
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rptr_reg];
    assign no_room  = (count_reg > sgi_pkg::CNT_W'(sgi_pkg::FIFO_DEPTH - 2));

endmodule

// ===== tb/sv/scan_gap_interpolation_tb.sv =====
// Self-checking testbench for the scan gap interpolation block.
module scan_gap_interpolation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Register index that lies past the last register and must be ignored.
    localparam logic [sgi_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    // Cycles to let pass once the expected results are drained.
    localparam int SETTLE_CYCLES   = 8;
    // Cycles without any accepted transaction before the run is abandoned.
    localparam int WATCHDOG_LIMIT  = 2000;
    // Random samples per configuration phase.
    localparam int ITEMS_PER_PHASE = 75;
    localparam int NUM_PHASES      = 7;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [sgi_pkg::CFG_IDX_W-1:0] cfg_index = sgi_pkg::CFG_MIN_VALID;
    logic [sgi_pkg::CFG_W-1:0]     cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [sgi_pkg::RANGE_W-1:0]   range_mm = '0;
    logic                          end_of_scan = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [sgi_pkg::RANGE_W-1:0]   out_range_mm;
    logic [sgi_pkg::COUNT_W-1:0]   repeat_count;
    logic                          is_filled;
    logic                          last_of_item;
    logic                          scan_done;

    int idle_cycles = 0;
    int in_calm_left = 0;
    int gap_burst_left = 0;

    scan_gap_interpolation u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .range_mm     (range_mm),
        .end_of_scan  (end_of_scan),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_range_mm (out_range_mm),
        .repeat_count (repeat_count),
        .is_filled    (is_filled),
        .last_of_item (last_of_item),
        .scan_done    (scan_done)
    );

    // Predicts the fill and sample results and compares them in order.
    class gap_fill_scoreboard;
        logic [sgi_pkg::CFG_W-1:0]   min_range;
        logic [sgi_pkg::CFG_W-1:0]   upper_range;
        logic [sgi_pkg::CFG_W-1:0]   fill_value;
        logic [sgi_pkg::RANGE_W-1:0] prev_valid;
        logic [sgi_pkg::RANGE_W-1:0] next_valid;
        logic [sgi_pkg::COUNT_W-1:0] run_len;
        sgi_pkg::result_t            expected_q[$];
        int                          mismatches;

        function new();
            min_range   = sgi_pkg::MIN_VALID_RST;
            upper_range = sgi_pkg::MAX_VALID_RST;
            fill_value  = sgi_pkg::FILL_DEF_RST;
            prev_valid  = sgi_pkg::FILL_DEF_RST;
            next_valid  = sgi_pkg::FILL_DEF_RST;
            run_len     = '0;
            mismatches  = 0;
        endfunction

        function logic [sgi_pkg::RANGE_W-1:0] midpoint_mm(logic [sgi_pkg::RANGE_W-1:0] a,
                                                          logic [sgi_pkg::RANGE_W-1:0] b);
            logic [sgi_pkg::RANGE_W:0] total;
            total = {1'b0, a} + {1'b0, b};
            return total[sgi_pkg::RANGE_W:1];
        endfunction

        function void note_config(logic [sgi_pkg::CFG_IDX_W-1:0] idx,
                                  logic [sgi_pkg::CFG_W-1:0] val);
            case (idx)
                sgi_pkg::CFG_MIN_VALID: min_range   = val;
                sgi_pkg::CFG_MAX_VALID: upper_range = val;
                sgi_pkg::CFG_FILL_DEF:  fill_value  = val;
                default: ;
            endcase
        endfunction

        function void note_sample(logic [sgi_pkg::RANGE_W-1:0] r, logic eos);
            sgi_pkg::result_t produced[2];
            sgi_pkg::result_t res;
            int               n;
            bit               in_window;
            n = 0;
            in_window = (r > min_range) && (r < upper_range);
            res = '0;
            if (in_window) begin
                // A valid sample closes any pending gap with a fill first.
                if (run_len != 0) begin
                    res.range_mm = midpoint_mm(prev_valid, r);
                    res.count    = run_len;
                    res.filled   = 1'b1;
                    produced[n]  = res;
                    n++;
                    next_valid = r;
                    run_len    = '0;
                end
                res.range_mm = r;
                res.count    = sgi_pkg::COUNT_W'(1);
                res.filled   = 1'b0;
                produced[n]  = res;
                n++;
                prev_valid = r;
            end
            else begin
                // Invalid samples lengthen the gap, saturating at the limit.
                if (run_len < sgi_pkg::MAX_SCAN_POINTS)
                    run_len++;
                if (eos) begin
                    res.range_mm = midpoint_mm(prev_valid, next_valid);
                    res.count    = run_len;
                    res.filled   = 1'b1;
                    produced[n]  = res;
                    n++;
                    prev_valid = next_valid;
                    run_len    = '0;
                end
            end
            if (n != 0)
                produced[n-1].last = 1'b1;
            // End of scan flags the final result and restores the held values.
            if (eos) begin
                if (n != 0)
                    produced[n-1].done = 1'b1;
                prev_valid = fill_value;
                next_valid = fill_value;
                run_len    = '0;
            end
            for (int i = 0; i < n; i++)
                expected_q.insert(expected_q.size(), produced[i]);
        endfunction

        function void check_result(sgi_pkg::result_t got);
            sgi_pkg::result_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: range %0d count %0d filled %0b last %0b done %0b",
                             got.range_mm, got.count, got.filled, got.last, got.done);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected range %0d count %0d filled %0b last %0b done %0b, got range %0d count %0d filled %0b last %0b done %0b",
                             want.range_mm, want.count, want.filled, want.last, want.done,
                             got.range_mm, got.count, got.filled, got.last, got.done);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    gap_fill_scoreboard sb = new();

    // Idle length: mostly none, often short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 60)
            return 0;
        else if (roll < 94)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    // Random range biased toward the valid window, its edges and runs of invalid samples.
    function automatic logic [sgi_pkg::RANGE_W-1:0] pick_range(logic [sgi_pkg::CFG_W-1:0] lo,
                                                               logic [sgi_pkg::CFG_W-1:0] hi);
        int roll;
        int l;
        int h;
        l = lo;
        h = hi;
        roll = $urandom_range(99, 0);
        if (gap_burst_left == 0 && roll < 6)
            gap_burst_left = $urandom_range(12, 2);
        if (gap_burst_left > 0) begin
            gap_burst_left--;
            roll = 70;
        end
        if (roll < 55 && h > l + 1)
            return sgi_pkg::RANGE_W'($urandom_range(h - 1, l + 1));
        else if (roll < 80) begin
            if ($urandom_range(1, 0) == 0)
                return sgi_pkg::RANGE_W'($urandom_range(l, 0));
            else
                return sgi_pkg::RANGE_W'($urandom_range(65535, h));
        end
        else if (roll < 88)
            return ($urandom_range(1, 0) == 0) ? lo : hi;
        else
            return sgi_pkg::RANGE_W'($urandom());
    endfunction

    // Clock generation.
    initial begin
        forever #5 clk = ~clk;
    end

    // Output stall: random stalls with calm stretches in between.
    initial begin
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left  = 0;
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (calm_left > 0) begin
                calm_left--;
                out_stall <= 1'b0;
            end
            else if ($urandom_range(49, 0) == 0) begin
                calm_left = $urandom_range(60, 20);
                out_stall <= 1'b0;
            end
            else if ($urandom_range(99, 0) < 25) begin
                stall_left = pick_gap();
                out_stall <= 1'b1;
            end
            else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Monitor both channels and track cycles without progress.
    always @(posedge clk) begin
        sgi_pkg::result_t got;
        bit               moved;
        moved = 1'b0;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                sb.note_sample(range_mm, end_of_scan);
                moved = 1'b1;
            end
            if (out_valid && !out_stall) begin
                got = '{range_mm: out_range_mm, count: repeat_count, filled: is_filled,
                        last: last_of_item, done: scan_done};
                sb.check_result(got);
                moved = 1'b1;
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    // Watchdog against a hung handshake.
    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Send one sample transaction after a random gap and wait for acceptance.
    task automatic send_sample(input logic [sgi_pkg::RANGE_W-1:0] r, input logic eos);
        int gap;
        gap = 0;
        if (in_calm_left > 0)
            in_calm_left--;
        else if ($urandom_range(49, 0) == 0)
            in_calm_left = $urandom_range(60, 20);
        else
            gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        range_mm    <= r;
        end_of_scan <= eos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Lower valid and wait until every expected result has come back.
    task automatic settle();
        in_valid <= 1'b0;
        // Let the monitor note the last accepted sample before the pending count is polled.
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the three registers, optionally poking the unused index too.
    task automatic program_window(input logic [sgi_pkg::CFG_W-1:0] lo,
                                  input logic [sgi_pkg::CFG_W-1:0] hi,
                                  input logic [sgi_pkg::CFG_W-1:0] fill, input bit poke_spare);
        logic [sgi_pkg::CFG_IDX_W-1:0] idx_list[4];
        logic [sgi_pkg::CFG_W-1:0]     val_list[4];
        int                            n;
        idx_list[0] = sgi_pkg::CFG_MIN_VALID;
        idx_list[1] = CFG_IDX_SPARE;
        idx_list[2] = sgi_pkg::CFG_MAX_VALID;
        idx_list[3] = sgi_pkg::CFG_FILL_DEF;
        val_list[0] = lo;
        val_list[1] = sgi_pkg::CFG_W'($urandom());
        val_list[2] = hi;
        val_list[3] = fill;
        n = 4;
        for (int i = 0; i < n; i++) begin
            if (i == 1 && !poke_spare)
                continue;
            cfg_we    <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_data  <= val_list[i];
            @(posedge clk);
            sb.note_config(idx_list[i], val_list[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // Main sequence.
    initial begin
        logic [sgi_pkg::CFG_W-1:0] lo;
        logic [sgi_pkg::CFG_W-1:0] hi;
        logic [sgi_pkg::CFG_W-1:0] fill;
        int                        span;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed samples at the reset window: edges, gaps, stale next value.
        send_sample(16'd0, 1'b0);
        send_sample(16'd65535, 1'b0);
        send_sample(16'd500, 1'b0);
        send_sample(16'd25000, 1'b0);
        send_sample(16'd501, 1'b0);
        send_sample(16'd24999, 1'b0);
        send_sample(16'd100, 1'b0);
        send_sample(16'd30000, 1'b0);
        send_sample(16'd12345, 1'b1);
        send_sample(16'd200, 1'b1);
        send_sample(16'd1000, 1'b0);
        send_sample(16'd5, 1'b0);
        send_sample(16'd3000, 1'b0);
        send_sample(16'd4000, 1'b0);
        send_sample(16'd9, 1'b1);
        send_sample(16'd700, 1'b1);
        // Gap left pending across a fill default write.
        send_sample(16'd2000, 1'b0);
        send_sample(16'd3, 1'b0);
        settle();
        program_window(sgi_pkg::MIN_VALID_RST, sgi_pkg::MAX_VALID_RST, 16'd1234, 1'b1);
        send_sample(16'd7, 1'b1);
        settle();

        // Widest window with the largest fill default: 17-bit sum of the mean.
        program_window(16'd0, 16'd65535, 16'd65535, 1'b0);
        send_sample(16'd0, 1'b0);
        send_sample(16'd65534, 1'b0);
        send_sample(16'd65535, 1'b1);
        send_sample(16'd1, 1'b1);
        settle();

        // Random phases over several windows, extremes and empty ones included.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    lo   = sgi_pkg::MIN_VALID_RST;
                    hi   = sgi_pkg::MAX_VALID_RST;
                    fill = sgi_pkg::FILL_DEF_RST;
                end
                1: begin lo = 16'd0; hi = 16'd65535; fill = 16'd0; end
                2: begin lo = 16'd65535; hi = 16'd0; fill = 16'd65535; end
                3: begin lo = 16'd3000; hi = 16'd3001; fill = sgi_pkg::CFG_W'($urandom()); end
                4: begin
                    lo   = sgi_pkg::CFG_W'($urandom_range(20000, 0));
                    span = $urandom_range(30000, 2);
                    hi   = sgi_pkg::CFG_W'(lo + span);
                    fill = sgi_pkg::CFG_W'($urandom());
                end
                5: begin lo = 16'd1000; hi = 16'd1004; fill = 16'd1002; end
                default: begin
                    lo   = sgi_pkg::CFG_W'($urandom());
                    hi   = sgi_pkg::CFG_W'($urandom());
                    fill = sgi_pkg::CFG_W'($urandom());
                end
            endcase
            program_window(lo, hi, fill, ($urandom_range(1, 0) == 0));
            repeat (ITEMS_PER_PHASE)
                send_sample(pick_range(lo, hi), ($urandom_range(19, 0) == 0));
            settle();
        end

        // Verdict.
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
